// File: hdl/sbec_pkg.sv
package sbec_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 32;
    localparam int TOL_W         = 16;
    localparam int ADDR_W        = 5;
    // working width for differences of coordinates and edges
    localparam int WORK_W        = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;

    localparam logic [2:0] REG_LEFT   = 3'd0;
    localparam logic [2:0] REG_RIGHT  = 3'd1;
    localparam logic [2:0] REG_BOTTOM = 3'd2;
    localparam logic [2:0] REG_TOP    = 3'd3;
    localparam logic [2:0] REG_TOL    = 3'd4;

    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    localparam logic signed [CFG_W-1:0] LEFT_RST   = 32'sd0;
    localparam logic signed [CFG_W-1:0] RIGHT_RST  = 32'sd65536;
    localparam logic signed [CFG_W-1:0] BOTTOM_RST = 32'sd0;
    localparam logic signed [CFG_W-1:0] TOP_RST    = 32'sd65536;
    localparam logic [TOL_W-1:0]        TOL_RST    = 16'd1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_seg_in;

    typedef struct packed {
        logic [1:0]                   crossing_count;
        logic [1:0]                   first_side;
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic [1:0]                   second_side;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
    } t_cross_out;

endpackage

// File: hdl/segment_box_edge_crossings_top.sv
// Segment / box edge crossings.
//
// Input channel: a segment beat (start and end point, Q16.16) is taken at a
// rising edge with start high and busy low. busy is low at all times except
// while reset is held, so a new segment may enter on every cycle.
// Result channel: o_done pulses for one cycle with o_res holding the crossing
// count and up to two crossing points, nearest first. Unused fields are zero.
// The receiver cannot stall; every result beat is presented exactly once.
// The depth is set by the quotient divider, which resolves one bit of the
// crossing parameter per stage, plus input, setup, multiply, round and select
// stages. Throughput is one segment per clock.
// The edge lanes (left, right, bottom, top) work in parallel; the select stage
// picks the first two hits in edge order and orders them by parameter.
// Configuration: APB registers at byte offsets 0 left, 4 right, 8 bottom,
// 12 top, 16 tolerance. Write only while no segment is in flight.
// Reset (synchronous, active low) empties the pipe and restores the box to
// the unit square with a tolerance of one LSB.
module segment_box_edge_crossings_top #(
    parameter int FRAC_BITS = sbec_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  sbec_pkg::t_seg_in            i_seg,
    output logic                         o_done,
    output sbec_pkg::t_cross_out         o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbec_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbec_pkg::CFG_W-1:0]   pwdata,
    output logic [sbec_pkg::CFG_W-1:0]   prdata,
    output logic                         pready
);
    import sbec_pkg::*;

    localparam int W  = WORK_W;
    localparam int CB = COORD_BITS;

    // ---------------- configuration registers ----------------
    logic signed [CFG_W-1:0] r_left, r_right, r_bottom, r_top;
    logic [TOL_W-1:0]        r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= LEFT_RST;
            r_right  <= RIGHT_RST;
            r_bottom <= BOTTOM_RST;
            r_top    <= TOP_RST;
            r_tol    <= TOL_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_LEFT:   r_left   <= pwdata;
                REG_RIGHT:  r_right  <= pwdata;
                REG_BOTTOM: r_bottom <= pwdata;
                REG_TOP:    r_top    <= pwdata;
                REG_TOL:    r_tol    <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LEFT:   prdata = r_left;
            REG_RIGHT:  prdata = r_right;
            REG_BOTTOM: prdata = r_bottom;
            REG_TOP:    prdata = r_top;
            REG_TOL:    prdata = CFG_W'(r_tol);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = ~i_rst_n;

    // ---------------- input register ----------------
    logic    r_in_v;
    t_seg_in r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start && !busy;
        end
        r_seg <= i_seg;
    end

    // ---------------- edge lanes ----------------
    logic signed [W-1:0] sx, sy, ex, ey, el, er, eb, et;
    logic signed [W-1:0] ln_a0 [4], ln_a1 [4], ln_b0 [4], ln_b1 [4];
    logic signed [W-1:0] ln_edge [4], ln_lo [4], ln_hi [4];

    always_comb begin
        sx = W'(r_seg.start_x);
        sy = W'(r_seg.start_y);
        ex = W'(r_seg.end_x);
        ey = W'(r_seg.end_y);
        el = W'(r_left);
        er = W'(r_right);
        eb = W'(r_bottom);
        et = W'(r_top);
        // left, right: cut along x, y must stay in [bottom, top]
        ln_a0[0] = sx; ln_a1[0] = ex; ln_b0[0] = sy; ln_b1[0] = ey;
        ln_edge[0] = el; ln_lo[0] = eb; ln_hi[0] = et;
        ln_a0[1] = sx; ln_a1[1] = ex; ln_b0[1] = sy; ln_b1[1] = ey;
        ln_edge[1] = er; ln_lo[1] = eb; ln_hi[1] = et;
        // bottom, top: cut along y, x must stay in [left, right]
        ln_a0[2] = sy; ln_a1[2] = ey; ln_b0[2] = sx; ln_b1[2] = ex;
        ln_edge[2] = eb; ln_lo[2] = el; ln_hi[2] = er;
        ln_a0[3] = sy; ln_a1[3] = ey; ln_b0[3] = sx; ln_b1[3] = ex;
        ln_edge[3] = et; ln_lo[3] = el; ln_hi[3] = er;
    end

    logic                          l_v   [4];
    logic [3:0]                    l_hit;
    logic [FRAC_BITS-1:0]          l_tq  [4];
    logic signed [CB-1:0]          l_b   [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        sbec_edge_lane #(
            .FRAC_BITS (FRAC_BITS),
            .IS_LOW    ((g == 0) || (g == 2))
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_in_v),
            .i_a0    (ln_a0[g]),
            .i_a1    (ln_a1[g]),
            .i_b0    (ln_b0[g]),
            .i_b1    (ln_b1[g]),
            .i_edge  (ln_edge[g]),
            .i_lo    (ln_lo[g]),
            .i_hi    (ln_hi[g]),
            .i_tol   (r_tol),
            .o_valid (l_v[g]),
            .o_hit   (l_hit[g]),
            .o_tq    (l_tq[g]),
            .o_b     (l_b[g])
        );
    end

    // ---------------- select and order ----------------
    logic signed [CB-1:0] px [4], py [4];
    logic [1:0]           cnt, idx0, idx1, s0, s1;
    logic                 swap;
    t_cross_out           n_res;

    always_comb begin
        px[0] = CB'(r_left);   py[0] = l_b[0];
        px[1] = CB'(r_right);  py[1] = l_b[1];
        px[2] = l_b[2];        py[2] = CB'(r_bottom);
        px[3] = l_b[3];        py[3] = CB'(r_top);

        // first two hits in edge order
        cnt  = 2'd0;
        idx0 = SIDE_LEFT;
        idx1 = SIDE_LEFT;
        for (int e = 0; e < 4; e++) begin
            if (l_hit[e] && (cnt != 2'd2)) begin
                if (cnt == 2'd0) begin
                    idx0 = 2'(e);
                end else begin
                    idx1 = 2'(e);
                end
                cnt = cnt + 2'd1;
            end
        end

        // nearest first; equal parameters keep edge order
        swap = (cnt == 2'd2) && (l_tq[idx0] > l_tq[idx1]);
        s0   = swap ? idx1 : idx0;
        s1   = swap ? idx0 : idx1;

        n_res = '0;
        n_res.crossing_count = cnt;
        if (cnt != 2'd0) begin
            n_res.first_side = s0;
            n_res.first_x    = px[s0];
            n_res.first_y    = py[s0];
        end
        if (cnt == 2'd2) begin
            n_res.second_side = s1;
            n_res.second_x    = px[s1];
            n_res.second_y    = py[s1];
        end
    end

    logic       r_done;
    t_cross_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= l_v[0];
        end
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: hdl/sbec_edge_lane.sv
module sbec_edge_lane #(
    parameter int FRAC_BITS = sbec_pkg::FRAC_BITS_DEF,
    parameter bit IS_LOW    = 1'b1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [sbec_pkg::WORK_W-1:0]     i_a0,
    input  logic signed [sbec_pkg::WORK_W-1:0]     i_a1,
    input  logic signed [sbec_pkg::WORK_W-1:0]     i_b0,
    input  logic signed [sbec_pkg::WORK_W-1:0]     i_b1,
    input  logic signed [sbec_pkg::WORK_W-1:0]     i_edge,
    input  logic signed [sbec_pkg::WORK_W-1:0]     i_lo,
    input  logic signed [sbec_pkg::WORK_W-1:0]     i_hi,
    input  logic [sbec_pkg::TOL_W-1:0]             i_tol,
    output logic                                   o_valid,
    output logic                                   o_hit,
    output logic [FRAC_BITS-1:0]                   o_tq,
    output logic signed [sbec_pkg::COORD_BITS-1:0] o_b
);
    import sbec_pkg::*;

    localparam int W  = WORK_W;
    localparam int F  = FRAC_BITS;
    localparam int PW = W + F + 1;
    localparam int TW = ((F > TOL_W) ? F : TOL_W) + 2;

    // setup stage
    logic signed [W-1:0] tol_s, lim_lo, lim_hi, num, den, num_f, den_f;
    logic                pre, ok;

    always_comb begin
        tol_s  = signed'(W'(i_tol));
        lim_lo = i_edge - tol_s;
        lim_hi = i_edge + tol_s;
        if (IS_LOW) begin
            pre = (i_a0 < lim_lo) || (i_a1 < lim_lo);
        end else begin
            pre = (i_a0 > lim_hi) || (i_a1 > lim_hi);
        end
        num = i_edge - i_a0;
        den = i_a1 - i_a0;
        if (den < 0) begin
            num_f = -num;
            den_f = -den;
        end else begin
            num_f = num;
            den_f = den;
        end
        ok = pre && (den_f != '0) && (num_f > 0) && (num_f < den_f);
    end

    // divider pipe: index 0 is the setup register, one quotient bit per stage
    logic               r_v   [0:F];
    logic               r_ok  [0:F];
    logic [W-1:0]       r_rem [0:F];
    logic [W-1:0]       r_den [0:F];
    logic [F-1:0]       r_q   [0:F];
    logic signed [W-1:0] r_db [0:F];
    logic signed [W-1:0] r_b0 [0:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_ok[0]  <= ok;
        r_rem[0] <= num_f;
        r_den[0] <= den_f;
        r_q[0]   <= '0;
        r_db[0]  <= i_b1 - i_b0;
        r_b0[0]  <= i_b0;
    end

    for (genvar k = 1; k <= F; k++) begin : g_div
        logic [W:0]   sh;
        logic         ge;
        logic [W-1:0] n_rem;

        always_comb begin
            sh    = {r_rem[k-1], 1'b0};
            ge    = sh >= {1'b0, r_den[k-1]};
            n_rem = ge ? W'(sh - {1'b0, r_den[k-1]}) : W'(sh);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_ok[k]  <= r_ok[k-1];
            r_rem[k] <= n_rem;
            r_den[k] <= r_den[k-1];
            r_q[k]   <= {r_q[k-1][F-2:0], ge};
            r_db[k]  <= r_db[k-1];
            r_b0[k]  <= r_b0[k-1];
        end
    end

    // multiply stage
    logic [TW-1:0]       t_ext, tol_ext, one_q;
    logic                tchk;
    logic signed [PW-1:0] prod;

    always_comb begin
        t_ext   = TW'(r_q[F]);
        tol_ext = TW'(i_tol);
        one_q   = TW'(1) << F;
        tchk    = r_ok[F] && (t_ext > tol_ext) && ((t_ext + tol_ext) < one_q);
        prod    = $signed({1'b0, r_q[F]}) * r_db[F];
    end

    logic                 r_m_v, r_m_ok;
    logic [F-1:0]         r_m_t;
    logic signed [PW-1:0] r_m_p;
    logic signed [W-1:0]  r_m_b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= r_v[F];
        end
        r_m_ok <= tchk;
        r_m_t  <= r_q[F];
        r_m_p  <= prod;
        r_m_b0 <= r_b0[F];
    end

    // round half up, offset, range test
    logic signed [PW-1:0] rq, bsh, bval, lo_t, hi_t;
    logic                 hit;

    always_comb begin
        rq   = r_m_p + (PW'(1) << (F - 1));
        bsh  = rq >>> F;
        bval = PW'(r_m_b0) + bsh;
        lo_t = PW'(i_lo) - signed'(PW'(i_tol));
        hi_t = PW'(i_hi) + signed'(PW'(i_tol));
        hit  = r_m_ok && (bval >= lo_t) && (bval <= hi_t);
    end

    logic                 r_r_v, r_r_hit;
    logic [F-1:0]         r_r_t;
    logic signed [COORD_BITS-1:0] r_r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else begin
            r_r_v <= r_m_v;
        end
        r_r_hit <= hit;
        r_r_t   <= r_m_t;
        r_r_b   <= bval[COORD_BITS-1:0];
    end

    assign o_valid = r_r_v;
    assign o_hit   = r_r_hit;
    assign o_tq    = r_r_t;
    assign o_b     = r_r_b;

endmodule

// File: hdl/sbec_checker.sv
module sbec_checker #(
    parameter int LAT = sbec_pkg::FRAC_BITS_DEF + 5
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input sbec_pkg::t_seg_in            i_seg,
    input logic                         o_done,
    input sbec_pkg::t_cross_out         o_res,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [sbec_pkg::ADDR_W-1:0]  paddr,
    input logic [sbec_pkg::CFG_W-1:0]   pwdata,
    input logic [sbec_pkg::CFG_W-1:0]   prdata,
    input logic                         pready
);
    import sbec_pkg::*;

    // every accepted beat yields a result
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted segment produced no result");

    // no result without a matching accepted beat
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without accepted segment");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.crossing_count != 2'd3))
        else $error("crossing count out of range");

    // fields of an unreported second crossing are zero
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.crossing_count != 2'd2)) |->
        (o_res.second_side == '0 && o_res.second_x == '0 && o_res.second_y == '0))
        else $error("unused second crossing not zero");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

bind segment_box_edge_crossings_top sbec_checker #(.LAT(FRAC_BITS + 5)) u_sbec_checker (.*);

// File: verif/segment_box_edge_crossings_checker.sv
// Watches the segment, result and APB channels, predicts each result and
// compares it with what the block returns.
module segment_box_edge_crossings_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  sbec_pkg::t_seg_in              i_seg,
    input  logic                           i_done,
    input  sbec_pkg::t_cross_out           i_res,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [sbec_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [sbec_pkg::CFG_W-1:0]     i_pwdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_pending
);
    import sbec_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    logic signed [CFG_W-1:0] box_l, box_r, box_b, box_t;
    logic [TOL_W-1:0]        tol_q;
    t_cross_out              crossing_q[$];
    int                      mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = crossing_q.size();

    // crossing of the segment with the line a = edge; other coordinate in [lo - tol, hi + tol]
    function automatic bit edge_hit(longint a0, longint a1, longint b0, longint b1,
                                    longint edge_v, longint lo, longint hi,
                                    longint tol, output longint t, output longint b);
        longint num;
        longint den;
        num = edge_v - a0;
        den = a1 - a0;
        t = 0;
        b = 0;
        if (den == 0) return 0;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0 || num >= den) return 0;
        t = (num << FB) / den;
        if (!(t > tol && t < (longint'(1) << FB) - tol)) return 0;
        // round to nearest, ties toward +inf
        b = b0 + ((t * (b1 - b0) + (longint'(1) << (FB - 1))) >>> FB);
        if (b < lo - tol || b > hi + tol) return 0;
        return 1;
    endfunction

    function automatic t_cross_out crossings_of(t_seg_in s);
        t_cross_out r;
        longint     sx, sy, ex, ey, lft, rgt, bot, tp, tol, t, b;
        longint     tq[2];
        longint     px[2];
        longint     py[2];
        logic [1:0] sd[2];
        int         n;
        bit         hit;
        sx = s.start_x; sy = s.start_y; ex = s.end_x; ey = s.end_y;
        lft = box_l; rgt = box_r; bot = box_b; tp = box_t;
        tol = longint'(tol_q);
        n = 0;
        for (int k = 0; k < 2; k++) begin
            tq[k] = 0; px[k] = 0; py[k] = 0; sd[k] = SIDE_LEFT;
        end
        for (int e = 0; e < 4 && n < 2; e++) begin
            hit = 0;
            case (e)
                0: if (sx < lft - tol || ex < lft - tol) begin
                    hit = edge_hit(sx, ex, sy, ey, lft, bot, tp, tol, t, b);
                    if (hit) begin px[n] = lft; py[n] = b; sd[n] = SIDE_LEFT; end
                end
                1: if (sx > rgt + tol || ex > rgt + tol) begin
                    hit = edge_hit(sx, ex, sy, ey, rgt, bot, tp, tol, t, b);
                    if (hit) begin px[n] = rgt; py[n] = b; sd[n] = SIDE_RIGHT; end
                end
                2: if (sy < bot - tol || ey < bot - tol) begin
                    hit = edge_hit(sy, ey, sx, ex, bot, lft, rgt, tol, t, b);
                    if (hit) begin px[n] = b; py[n] = bot; sd[n] = SIDE_BOTTOM; end
                end
                default: if (sy > tp + tol || ey > tp + tol) begin
                    hit = edge_hit(sy, ey, sx, ex, tp, lft, rgt, tol, t, b);
                    if (hit) begin px[n] = b; py[n] = tp; sd[n] = SIDE_TOP; end
                end
            endcase
            if (hit) begin
                tq[n] = t;
                n++;
            end
        end
        r.crossing_count = n[1:0];
        if (n == 2 && tq[0] > tq[1]) begin
            r.first_side  = sd[1]; r.first_x  = px[1][31:0]; r.first_y  = py[1][31:0];
            r.second_side = sd[0]; r.second_x = px[0][31:0]; r.second_y = py[0][31:0];
        end else begin
            r.first_side  = sd[0]; r.first_x  = px[0][31:0]; r.first_y  = py[0][31:0];
            r.second_side = sd[1]; r.second_x = px[1][31:0]; r.second_y = py[1][31:0];
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, longint exp_v, longint act_v);
        if (mismatches < 10)
            $display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_cross_out want;
        if (!i_rst_n) begin
            box_l <= LEFT_RST;
            box_r <= RIGHT_RST;
            box_b <= BOTTOM_RST;
            box_t <= TOP_RST;
            tol_q <= TOL_RST;
            crossing_q.delete();
            mismatches <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_LEFT:   box_l <= i_pwdata;
                    REG_RIGHT:  box_r <= i_pwdata;
                    REG_BOTTOM: box_b <= i_pwdata;
                    REG_TOP:    box_t <= i_pwdata;
                    REG_TOL:    tol_q <= i_pwdata[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                crossing_q.push_back(crossings_of(i_seg));
            if (i_done) begin
                if (crossing_q.size() == 0) begin
                    note_mismatch("unexpected result beat", 0, 1);
                end else begin
                    want = crossing_q.pop_front();
                    if (want.crossing_count != i_res.crossing_count)
                        note_mismatch("crossing_count", want.crossing_count,
                                      i_res.crossing_count);
                    if (want.first_side != i_res.first_side)
                        note_mismatch("first_side", want.first_side, i_res.first_side);
                    if (want.first_x != i_res.first_x)
                        note_mismatch("first_x", want.first_x, i_res.first_x);
                    if (want.first_y != i_res.first_y)
                        note_mismatch("first_y", want.first_y, i_res.first_y);
                    if (want.second_side != i_res.second_side)
                        note_mismatch("second_side", want.second_side, i_res.second_side);
                    if (want.second_x != i_res.second_x)
                        note_mismatch("second_x", want.second_x, i_res.second_x);
                    if (want.second_y != i_res.second_y)
                        note_mismatch("second_y", want.second_y, i_res.second_y);
                end
            end
        end
    end

endmodule

// File: verif/segment_box_edge_crossings_top_tb.sv
// Stimulus and verdict; prediction and comparison live in the checker.
module segment_box_edge_crossings_top_tb;
    import sbec_pkg::*;

    localparam longint ONE       = 65536;   // 1.0 in Q16.16
    localparam int     LATENCY   = FRAC_BITS_DEF + 5;
    localparam int     STALL_MAX = 5000;    // cycles without any beat

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_seg_in            i_seg;
    logic               o_done;
    t_cross_out         o_res;
    logic               psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]  paddr;
    logic [CFG_W-1:0]   pwdata, prdata;
    int                 fail_count, pending, quiet_cycles;

    // box as currently programmed, used to aim random segments
    longint cur_l, cur_r, cur_b, cur_t;

    segment_box_edge_crossings_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_seg(i_seg), .o_done(o_done), .o_res(o_res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    segment_box_edge_crossings_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_seg(i_seg), .i_done(o_done), .i_res(o_res),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // watchdog: any accepted beat (segment, result or register access) rearms it
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_MAX) begin
                $display("[segment_box_edge_crossings_top] ERROR");
                $finish;
            end
        end
    end

    // setup cycle then access cycle; pready is tied high in the block
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // waits for the pipe to drain before writing the registers
    task automatic set_box(longint l, longint r, longint b, longint t, int tol);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        reg_write(REG_LEFT, l[31:0]);
        reg_write(REG_RIGHT, r[31:0]);
        reg_write(REG_BOTTOM, b[31:0]);
        reg_write(REG_TOP, t[31:0]);
        reg_write(REG_TOL, tol);
        cur_l = l; cur_r = r; cur_b = b; cur_t = t;
    endtask

    // start stays high across back-to-back beats; dropped only for gaps
    task automatic send_seg(longint sx, longint sy, longint ex, longint ey, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_seg.start_x <= sx[31:0];
        i_seg.start_y <= sy[31:0];
        i_seg.end_x   <= ex[31:0];
        i_seg.end_y   <= ey[31:0];
        do @(posedge i_clk); while (busy);
    endtask

    // mostly near the span [lo, hi]; sometimes on an edge or anywhere at all
    function automatic longint pick_coord(longint lo, longint hi);
        longint span, v;
        int     sel;
        span = (hi > lo) ? hi - lo : lo - hi;
        span = span + 2 * ONE;
        sel  = $urandom_range(0, 11);
        if (sel == 0) return longint'($signed($urandom));
        if (sel == 1) return lo;
        if (sel == 2) return hi;
        v = (lo < hi ? lo : hi) - span / 2
            + longint'({$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF) % (2 * span + 1);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v;
    endfunction

    task automatic random_phase(int count, int idle_pct);
        longint sx, sy;
        for (int k = 0; k < count; k++) begin
            sx = pick_coord(cur_l, cur_r);
            sy = pick_coord(cur_b, cur_t);
            // some axis-parallel segments to hit the zero-divisor path
            case ($urandom_range(0, 9))
                0:       send_seg(sx, sy, pick_coord(cur_l, cur_r), sy, idle_pct);
                1:       send_seg(sx, sy, sx, pick_coord(cur_b, cur_t), idle_pct);
                default: send_seg(sx, sy, pick_coord(cur_l, cur_r),
                                  pick_coord(cur_b, cur_t), idle_pct);
            endcase
        end
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_seg   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cur_l = 0; cur_r = ONE; cur_b = 0; cur_t = ONE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats against the reset box (unit square, tolerance 1 LSB)
        send_seg(-ONE, ONE / 2, 2 * ONE, ONE / 2, 0);       // through left and right
        send_seg(2 * ONE, ONE / 2, -ONE, ONE / 2, 0);       // reversed: order swaps
        send_seg(ONE / 2, -ONE, ONE / 2, 2 * ONE, 0);       // bottom and top
        send_seg(-ONE, -ONE, 2 * ONE, 2 * ONE, 0);          // corners, reported per edge
        send_seg(-ONE, 0, 2 * ONE, 0, 0);                   // along the bottom edge
        send_seg(-ONE, ONE / 2, -ONE, 2 * ONE, 0);          // parallel to left edge
        send_seg(ONE / 4, ONE / 4, ONE / 2, ONE / 2, 0);    // fully inside
        send_seg(-ONE, ONE / 2, ONE / 2, ONE / 2, 0);       // one crossing
        send_seg(0, ONE / 2, 2 * ONE, ONE / 2, 0);          // start on the left edge
        send_seg(-ONE, ONE / 2, 0, ONE / 2, 0);             // end on the left edge
        send_seg(-ONE, ONE / 2, ONE / 2, 2 * ONE, 0);       // misses past the top-left corner
        send_seg(-ONE, 3 * ONE, 3 * ONE, -ONE, 0);          // through the top-right corner
        send_seg(-2, ONE / 2, 2, ONE / 2, 0);               // start just past the left tolerance band
        send_seg(-ONE, ONE + 1, 2 * ONE, ONE + 1, 0);       // just above top, inside the tolerance
        send_seg(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 0);
        send_seg(-64'sd2147483648, -64'sd2147483648,
                 -64'sd2147483648, -64'sd2147483648, 0);
        send_seg(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647, 0);
        send_seg(64'sd2147483647, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 0);
        send_seg(-64'sd2147483648, ONE / 3, 64'sd2147483647, ONE / 3, 0);
        start <= 1'b0;
        @(posedge i_clk);

        random_phase(80, 0);
        random_phase(60, 75);

        set_box(-5 * ONE, 3 * ONE, -2 * ONE, 7 * ONE, 0);
        random_phase(65, 38);
        set_box(-ONE, ONE, -ONE, ONE, 65535);               // widest tolerance
        random_phase(65, 0);
        set_box(-64'sd2147483648, 64'sd2147483647,
                -64'sd2147483648, 64'sd2147483647, 0);      // box at the extremes
        random_phase(60, 75);
        set_box(3 * ONE, -ONE, 2 * ONE, -2 * ONE, 7);       // inverted box
        random_phase(60, 38);
        set_box(100, 300, -200, 900, 3);                    // tiny box
        random_phase(81, 0);
        set_box(-64'sd2147483648, -64'sd2147483648 + 10 * ONE,
                64'sd2147483647 - 10 * ONE, 64'sd2147483647, 255);
        random_phase(60, 75);

        // drain, then let the pipe settle
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[segment_box_edge_crossings_top] OK");
        else
            $display("[segment_box_edge_crossings_top] ERROR");
        $finish;
    end

endmodule
